>>> src/ising_pkg.sv
// Shared types and constants for the Ising lattice spin update block.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ising_pkg;

  // lattice geometry, side must be a power of two
  localparam int LATTICE_SIDE = 64;
  localparam int SIDE_BITS    = $clog2(LATTICE_SIDE);
  localparam int SITE_COUNT   = LATTICE_SIDE * LATTICE_SIDE;
  localparam int ADDR_W       = 2 * SIDE_BITS;

  // field widths
  localparam int COORD_W     = 6;
  localparam int RAND_W      = 32;
  localparam int THR_W       = 32;
  localparam int MAG_W       = 14;
  localparam int EN_W        = 15;
  localparam int DE_W        = 5;
  localparam int CMD_W       = 2;
  localparam int CFG_INDEX_W = 1;

  // input item packing in tdata
  localparam int X_LSB      = 0;
  localparam int Y_LSB      = X_LSB + COORD_W;
  localparam int RAND_LSB   = Y_LSB + COORD_W;
  localparam int SPIN_BIT   = RAND_LSB + RAND_W;
  localparam int IN_TDATA_W = ((SPIN_BIT + 1 + 7) / 8) * 8;

  // result item packing in tdata
  localparam int ACC_BIT     = 0;
  localparam int SPIN_AFTER  = 1;
  localparam int MAG_LSB     = 2;
  localparam int EN_LSB      = MAG_LSB + MAG_W;
  localparam int OUT_USED_W  = EN_LSB + EN_W;
  localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;

  // totals for a uniform lattice
  localparam logic signed [MAG_W-1:0] MAG_FULL    = MAG_W'(SITE_COUNT);
  localparam logic signed [EN_W-1:0]  EN_FULL     = EN_W'(-2 * SITE_COUNT);
  localparam logic signed [MAG_W-1:0] MAG_TWO     = MAG_W'(2);
  localparam logic signed [MAG_W-1:0] MAG_TWO_NEG = MAG_W'(-2);

  // energy steps that need a random draw
  localparam logic signed [DE_W-1:0] DE_FOUR  = DE_W'(4);
  localparam logic signed [DE_W-1:0] DE_EIGHT = DE_W'(8);

  typedef enum logic [CMD_W-1:0] {
    CMD_TRIAL = 2'd0,
    CMD_FILL  = 2'd1,
    CMD_LOAD  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_THR_FOUR  = 1'b0,
    CFG_THR_EIGHT = 1'b1
  } cfg_reg_t;

  // which pair of sites the two read ports fetch
  typedef enum logic [1:0] {
    RD_INPUT  = 2'd0,
    RD_SECOND = 2'd1,
    RD_THIRD  = 2'd2
  } rd_sel_t;

  typedef struct packed {
    logic    load_item;
    rd_sel_t rd_sel;
    logic    cap_first;
    logic    cap_second;
    logic    eval;
    logic    finish;
    logic    sweep_write;
  } ctrl_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

>>> src/ising_ram.sv
// Generic single-write, dual-read RAM with registered read data.
// No dependencies; used for the spin lattice.
`timescale 1ns / 1ps
`default_nettype none

module ising_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // two registered read ports
  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

`default_nettype wire

>>> src/ising_ctrl.sv
// Sequencing controller for the Ising spin update block.
// Depends on ising_pkg; drives the datapath through ctrl_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module ising_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic [ising_pkg::CMD_W-1:0] in_cmd,
  output logic                    in_ready,
  input  ising_pkg::dp_status_t   status,
  output ising_pkg::ctrl_cmd_t    cmd
);

  import ising_pkg::*;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_RD2   = 7'b0000100,
    ST_RD3   = 7'b0001000,
    ST_EVAL  = 7'b0010000,
    ST_FILL  = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  // state register, reset starts the clearing sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_next     = state;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.rd_sel     = RD_INPUT;
    unique case (state)
      ST_CLEAR: begin
        cmd.sweep_write = 1'b1;
        if (status.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          if (cmd_t'(in_cmd) == CMD_FILL) begin
            state_next = ST_FILL;
          end else begin
            state_next = ST_RD2;
          end
        end
      end
      ST_RD2: begin
        cmd.rd_sel    = RD_SECOND;
        cmd.cap_first = 1'b1;
        state_next    = ST_RD3;
      end
      ST_RD3: begin
        cmd.rd_sel     = RD_THIRD;
        cmd.cap_second = 1'b1;
        state_next     = ST_EVAL;
      end
      ST_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = ST_DONE;
      end
      ST_FILL: begin
        cmd.sweep_write = 1'b1;
        if (status.sweep_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> src/ising_dp.sv
// Datapath of the Ising spin update block: item registers, neighbour
// capture, acceptance test, totals and result register. Depends on ising_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ising_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  ising_pkg::ctrl_cmd_t                 cmd,
  output ising_pkg::dp_status_t                status,
  input  logic [ising_pkg::IN_TDATA_W-1:0]     in_data,
  input  logic [ising_pkg::CMD_W-1:0]          in_cmd,
  input  logic                                 cfg_valid,
  input  logic [ising_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [ising_pkg::THR_W-1:0]          cfg_data,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic [ising_pkg::OUT_TDATA_W-1:0]    out_data,
  output logic [ising_pkg::ADDR_W-1:0]         rd_addr_a,
  output logic [ising_pkg::ADDR_W-1:0]         rd_addr_b,
  input  logic                                 rd_data_a,
  input  logic                                 rd_data_b,
  output logic                                 wr_en,
  output logic [ising_pkg::ADDR_W-1:0]         wr_addr,
  output logic                                 wr_data
);

  import ising_pkg::*;

  logic [SIDE_BITS-1:0]       x_in;
  logic [SIDE_BITS-1:0]       y_in;
  logic [SIDE_BITS-1:0]       x_in_p;
  logic [SIDE_BITS-1:0]       x;
  logic [SIDE_BITS-1:0]       y;
  logic [SIDE_BITS-1:0]       x_p;
  logic [SIDE_BITS-1:0]       x_m;
  logic [SIDE_BITS-1:0]       y_p;
  logic [SIDE_BITS-1:0]       y_m;
  logic [RAND_W-1:0]          rnd;
  logic                       want;
  cmd_t                       item_cmd;
  logic                       sweep_val;
  logic [ADDR_W-1:0]          sweep_cnt;
  logic [THR_W-1:0]           thr_four;
  logic [THR_W-1:0]           thr_eight;
  logic                       spin_c;
  logic                       nb0;
  logic                       nb1;
  logic                       nb2;
  logic [2:0]                 nb_count;
  logic signed [DE_W:0]       de_wide;
  logic signed [DE_W-1:0]     de_up;
  logic signed [DE_W-1:0]     de;
  logic                       ok;
  logic                       flip_n;
  logic                       acc_n;
  logic                       flip;
  logic                       acc;
  logic signed [DE_W-1:0]     de_r;
  logic signed [MAG_W-1:0]    mag_total;
  logic signed [EN_W-1:0]     en_total;
  logic signed [MAG_W-1:0]    mag_next;
  logic signed [EN_W-1:0]     en_next;
  logic                       spin_after_next;
  logic                       out_acc;
  logic                       out_spin;
  logic signed [MAG_W-1:0]    out_mag;
  logic signed [EN_W-1:0]     out_en;

  // site fields reduced to the lattice side
  assign x_in   = in_data[X_LSB +: SIDE_BITS];
  assign y_in   = in_data[Y_LSB +: SIDE_BITS];
  assign x_in_p = x_in + 1'b1;
  assign x_p    = x + 1'b1;
  assign x_m    = x - 1'b1;
  assign y_p    = y + 1'b1;
  assign y_m    = y - 1'b1;

  // item registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      x        <= x_in;
      y        <= y_in;
      rnd      <= in_data[RAND_LSB +: RAND_W];
      want     <= in_data[SPIN_BIT];
      item_cmd <= cmd_t'(in_cmd);
    end
  end

  // sweep value: all up after reset, the item's spin for a fill
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_val <= 1'b1;
      sweep_cnt <= '0;
    end else begin
      if (cmd.load_item) begin
        sweep_val <= in_data[SPIN_BIT];
      end
      if (cmd.sweep_write) begin
        sweep_cnt <= sweep_cnt + 1'b1;
      end
    end
  end

  // threshold registers
  always_ff @(posedge clk) begin
    if (rst) begin
      thr_four  <= '0;
      thr_eight <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_THR_FOUR:  thr_four  <= cfg_data;
        CFG_THR_EIGHT: thr_eight <= cfg_data;
        default: ;
      endcase
    end
  end

  // read address pairs: centre and right, left and down, up
  always_comb begin
    case (cmd.rd_sel)
      RD_INPUT: begin
        rd_addr_a = {y_in, x_in};
        rd_addr_b = {y_in, x_in_p};
      end
      RD_SECOND: begin
        rd_addr_a = {y, x_m};
        rd_addr_b = {y_p, x};
      end
      RD_THIRD: begin
        rd_addr_a = {y_m, x};
        rd_addr_b = {y_m, x};
      end
      default: begin
        rd_addr_a = {y, x};
        rd_addr_b = {y, x};
      end
    endcase
  end

  // neighbour capture
  always_ff @(posedge clk) begin
    if (cmd.cap_first) begin
      spin_c <= rd_data_a;
      nb0    <= rd_data_b;
    end
    if (cmd.cap_second) begin
      nb1 <= rd_data_a;
      nb2 <= rd_data_b;
    end
  end

  // energy change: the last neighbour arrives straight from the read port
  always_comb begin
    nb_count = {2'b00, nb0} + {2'b00, nb1} + {2'b00, nb2} + {2'b00, rd_data_a};
    de_wide  = $signed({1'b0, nb_count, 2'b00}) - $signed(6'd8);
    de_up    = de_wide[DE_W-1:0];
    de       = spin_c ? de_up : -de_up;
    ok       = de[DE_W-1] || (de == '0)
            || ((de == DE_FOUR) && (rnd < thr_four))
            || ((de == DE_EIGHT) && (rnd < thr_eight));
  end

  // per command decision, a load that changes the spin acts as a flip
  always_comb begin
    unique case (item_cmd)
      CMD_TRIAL: begin
        flip_n = ok;
        acc_n  = ok;
      end
      CMD_LOAD: begin
        flip_n = (want != spin_c);
        acc_n  = 1'b1;
      end
      CMD_FILL: begin
        flip_n = 1'b0;
        acc_n  = 1'b1;
      end
      CMD_NONE: begin
        flip_n = 1'b0;
        acc_n  = 1'b0;
      end
      default: begin
        flip_n = 1'b0;
        acc_n  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      flip <= flip_n;
      acc  <= acc_n;
      de_r <= de;
    end
  end

  // totals and spin after the item
  always_comb begin
    mag_next        = mag_total;
    en_next         = en_total;
    spin_after_next = flip ? ~spin_c : spin_c;
    if (item_cmd == CMD_FILL) begin
      mag_next        = want ? MAG_FULL : -MAG_FULL;
      en_next         = EN_FULL;
      spin_after_next = want;
    end else if (flip) begin
      mag_next = mag_total + (spin_c ? MAG_TWO_NEG : MAG_TWO);
      en_next  = en_total + EN_W'(de_r);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mag_total <= MAG_FULL;
      en_total  <= EN_FULL;
    end else if (cmd.finish) begin
      mag_total <= mag_next;
      en_total  <= en_next;
    end
  end

  // lattice write: sweep or the flipped spin
  always_comb begin
    wr_en   = cmd.sweep_write || (cmd.finish && flip && (item_cmd != CMD_FILL));
    wr_addr = cmd.sweep_write ? sweep_cnt : {y, x};
    wr_data = cmd.sweep_write ? sweep_val : ~spin_c;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_acc  <= (item_cmd == CMD_FILL) ? 1'b1 : acc;
      out_spin <= spin_after_next;
      out_mag  <= mag_next;
      out_en   <= en_next;
    end
  end

  always_comb begin
    out_data               = '0;
    out_data[ACC_BIT]      = out_acc;
    out_data[SPIN_AFTER]   = out_spin;
    out_data[MAG_LSB +: MAG_W] = out_mag;
    out_data[EN_LSB +: EN_W]   = out_en;
  end

  // status to the controller
  assign status.sweep_last = &sweep_cnt;
  assign status.out_free   = !out_valid || out_ready;

endmodule

`default_nettype wire

>>> src/ising_metropolis_spin_update_top.sv
// Top level of the Ising Metropolis spin update block.
// Depends on ising_pkg, ising_ram, ising_ctrl and ising_dp.
`timescale 1ns / 1ps
`default_nettype none

// Periodic 64 x 64 lattice of +1/-1 spins with running magnetization and
// bond energy. After reset the block sweeps the lattice to all spins up,
// one site a cycle, before it takes the first item; configuration writes
// are taken at any time. For trial, load and unused commands two read
// ports fetch the centre and four neighbours at acceptance, in ST_RD2 and
// in ST_RD3, then ST_EVAL decides and ST_DONE writes back. A fill makes
// one memory write per site in ST_FILL, then passes to ST_DONE. One item
// is in work at a time; a finished result waits in an output register
// while the next item is taken, and the next result holds in ST_DONE
// until that register is free.
module ising_metropolis_spin_update_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // site_x[5:0], site_y[11:6], random_fraction[43:12], new_spin[44]
  input  logic [ising_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // cmd[1:0]
  input  logic [ising_pkg::CMD_W-1:0]          s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // accepted[0], spin_after[1], magnetization[15:2], energy[30:16]
  output logic [ising_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ising_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [ising_pkg::THR_W-1:0]          cfg_data
);

  import ising_pkg::*;

  ctrl_cmd_t         cmd;
  dp_status_t        status;
  logic [ADDR_W-1:0] rd_addr_a;
  logic [ADDR_W-1:0] rd_addr_b;
  logic              rd_data_a;
  logic              rd_data_b;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic              wr_data;

  // thresholds are plain registers, always writable
  assign cfg_ready = 1'b1;

  // spin lattice
  ising_ram #(
    .WIDTH (1),
    .DEPTH (SITE_COUNT)
  ) u_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  // controller
  ising_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_cmd   (s_axis_tuser),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath
  ising_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (s_axis_tdata),
    .in_cmd    (s_axis_tuser),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the Ising Metropolis spin update block: directed items,
// then random trials, loads and fills over several threshold settings.
// Depends on ising_pkg and ising_metropolis_spin_update_top.
`timescale 1ns / 1ps

module testbench;
  import ising_pkg::*;

  localparam int DIRECTED_COUNT  = 21;
  localparam int PHASE_COUNT     = 6;
  localparam int ITEMS_PER_PHASE = 240;
  localparam int WATCHDOG_LIMIT  = 20000;
  localparam int MAX_REPORTS     = 10;
  localparam int SETTLE_CYCLES   = 20;

  typedef logic [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic                    accepted;
    logic                    spin_after;
    logic signed [MAG_W-1:0] mag;
    logic signed [EN_W-1:0]  en;
  } outcome_t;

  typedef struct {
    cmd_t              cmd;
    coord_t            x;
    coord_t            y;
    logic [RAND_W-1:0] rnd;
    logic              spin;
    bit                fixed;
    outcome_t          fixed_out;
  } spin_item_t;

  typedef struct {
    cmd_t              cmd;
    int                x;
    int                y;
    logic [RAND_W-1:0] rnd;
    bit                spin;
    bit                fixed;
    bit                acc;
    bit                spin_after;
    int                mag;
    int                en;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [CMD_W-1:0]       s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid     = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index     = '0;
  logic [THR_W-1:0]       cfg_data      = '0;

  // typed expectation travelling alongside the item being offered
  bit       item_fixed     = 1'b0;
  outcome_t item_fixed_out = '0;

  // no idling on either side when set
  bit calm = 1'b0;

  // lattice model and its totals
  bit               lattice [SITE_COUNT];
  int               mag_total;
  int               en_total;
  logic [THR_W-1:0] thr_four  = '0;
  logic [THR_W-1:0] thr_eight = '0;

  // stimulus side copies of the thresholds and the hot region
  logic [THR_W-1:0] drv_thr_four  = '0;
  logic [THR_W-1:0] drv_thr_eight = '0;
  coord_t           win_x = '0;
  coord_t           win_y = '0;

  outcome_t pending_results [$];
  int       mismatch_count = 0;
  int       idle_cycles    = 0;

  directed_row_t    directed_rows [DIRECTED_COUNT];
  logic [THR_W-1:0] phase_four  [PHASE_COUNT];
  logic [THR_W-1:0] phase_eight [PHASE_COUNT];

  ising_metropolis_spin_update_top DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  // lattice starts all up
  initial begin
    foreach (lattice[i]) lattice[i] = 1'b1;
    mag_total = SITE_COUNT;
    en_total  = -2 * SITE_COUNT;
  end

  function automatic int spin_sign(int x, int y);
    return lattice[y * LATTICE_SIDE + x] ? 1 : -1;
  endfunction

  // four wrapped neighbours
  function automatic int neighbour_total(int x, int y);
    return spin_sign((x + 1) % LATTICE_SIDE, y)
         + spin_sign((x + LATTICE_SIDE - 1) % LATTICE_SIDE, y)
         + spin_sign(x, (y + 1) % LATTICE_SIDE)
         + spin_sign(x, (y + LATTICE_SIDE - 1) % LATTICE_SIDE);
  endfunction

  // applies one item to the lattice model and returns the result it gives
  function automatic outcome_t update_site(cmd_t c, int x, int y, logic [RAND_W-1:0] rnd,
                                           logic spin_bit);
    int       site;
    int       s;
    int       de;
    int       diff;
    bit       flip;
    outcome_t o;
    x = x % LATTICE_SIDE;
    y = y % LATTICE_SIDE;
    site = y * LATTICE_SIDE + x;
    o = '0;
    case (c)
      CMD_TRIAL: begin
        s = spin_sign(x, y);
        de = 2 * s * neighbour_total(x, y);
        flip = (de <= 0) || (de == 4 && rnd < thr_four) || (de == 8 && rnd < thr_eight);
        if (flip) begin
          lattice[site] = (s < 0);
          mag_total -= 2 * s;
          en_total += de;
          o.accepted = 1'b1;
        end
      end
      CMD_FILL: begin
        foreach (lattice[i]) lattice[i] = spin_bit;
        mag_total = spin_bit ? SITE_COUNT : -SITE_COUNT;
        en_total = -2 * SITE_COUNT;
        o.accepted = 1'b1;
      end
      CMD_LOAD: begin
        s = spin_sign(x, y);
        diff = (spin_bit ? 1 : -1) - s;
        mag_total += diff;
        en_total -= diff * neighbour_total(x, y);
        lattice[site] = spin_bit;
        o.accepted = 1'b1;
      end
      default: ;
    endcase
    o.spin_after = lattice[site];
    o.mag = MAG_W'(mag_total);
    o.en  = EN_W'(en_total);
    return o;
  endfunction

  task automatic report_mismatch(string what, outcome_t wanted, outcome_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t %s: expected acc %0d spin %0d mag %0d en %0d, got acc %0d spin %0d mag %0d en %0d",
               $time, what, wanted.accepted, wanted.spin_after, wanted.mag, wanted.en,
               got.accepted, got.spin_after, got.mag, got.en);
  endtask

  // handshakes: predict on input, check on output, watchdog on neither
  always @(posedge clk) begin : result_check
    outcome_t predicted;
    outcome_t got;
    outcome_t wanted;
    bit       moved;
    moved = 1'b0;
    if (cfg_valid && cfg_ready) begin
      moved = 1'b1;
      if (cfg_index == CFG_THR_FOUR) thr_four = cfg_data;
      else thr_eight = cfg_data;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      moved = 1'b1;
      predicted = update_site(cmd_t'(s_axis_tuser), int'(s_axis_tdata[X_LSB +: COORD_W]),
                              int'(s_axis_tdata[Y_LSB +: COORD_W]),
                              s_axis_tdata[RAND_LSB +: RAND_W], s_axis_tdata[SPIN_BIT]);
      pending_results.push_back(item_fixed ? item_fixed_out : predicted);
    end
    if (m_axis_tvalid && m_axis_tready) begin
      moved = 1'b1;
      got.accepted   = m_axis_tdata[ACC_BIT];
      got.spin_after = m_axis_tdata[SPIN_AFTER];
      got.mag        = m_axis_tdata[MAG_LSB +: MAG_W];
      got.en         = m_axis_tdata[EN_LSB +: EN_W];
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", '0, got);
      end else begin
        wanted = pending_results.pop_front();
        if (got.accepted !== wanted.accepted || got.spin_after !== wanted.spin_after ||
            got.mag !== wanted.mag || got.en !== wanted.en)
          report_mismatch("result mismatch", wanted, got);
      end
    end
    if (moved) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("testbench failed");
        $finish;
      end
    end
  end

  // result side: random stall bursts between ready stretches
  initial begin : result_sink
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(0, 15)) @(posedge clk);
    end
  end

  task automatic send_item(spin_item_t it);
    logic [IN_TDATA_W-1:0] word;
    word = '0;
    word[X_LSB +: COORD_W]   = it.x;
    word[Y_LSB +: COORD_W]   = it.y;
    word[RAND_LSB +: RAND_W] = it.rnd;
    word[SPIN_BIT]           = it.spin;
    s_axis_tvalid  <= 1'b1;
    s_axis_tdata   <= word;
    s_axis_tuser   <= it.cmd;
    item_fixed     <= it.fixed;
    item_fixed_out <= it.fixed_out;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (!calm && $urandom_range(0, 9) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // holds the sender off until every pending result is back
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // both registers back to back, valid held high across them
  task automatic set_thresholds(logic [THR_W-1:0] four, logic [THR_W-1:0] eight);
    for (int i = 0; i < 2; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= (i == 0) ? CFG_THR_FOUR : CFG_THR_EIGHT;
      cfg_data  <= (i == 0) ? four : eight;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    drv_thr_four  = four;
    drv_thr_eight = eight;
  endtask

  // mostly trials in a small hot region, with random fractions near the thresholds
  function automatic spin_item_t random_item();
    spin_item_t it;
    int         pick;
    it.x = coord_t'($urandom);
    it.y = coord_t'($urandom);
    it.rnd = $urandom;
    it.spin = 1'($urandom);
    it.fixed = 1'b0;
    it.fixed_out = '0;
    pick = $urandom_range(0, 99);
    if (pick == 0) begin
      it.cmd = CMD_FILL;
    end else if (pick < 4) begin
      it.cmd = CMD_NONE;
    end else begin
      if (pick < 14) it.cmd = CMD_LOAD;
      else it.cmd = CMD_TRIAL;
      if ($urandom_range(0, 3) != 0) begin
        it.x = win_x + coord_t'($urandom_range(0, 7));
        it.y = win_y + coord_t'($urandom_range(0, 7));
      end
      if (it.cmd == CMD_TRIAL) begin
        case ($urandom_range(0, 9))
          0, 1: it.rnd = drv_thr_four + $urandom_range(0, 2) - 1;
          2, 3: it.rnd = drv_thr_eight + $urandom_range(0, 2) - 1;
          4: begin
            if ($urandom_range(0, 1) == 1) it.rnd = '1;
            else it.rnd = '0;
          end
          default: ;
        endcase
      end
    end
    return it;
  endfunction

  initial begin : stimulus
    spin_item_t it;

    // cmd, x, y, random, spin, typed, accepted, spin after, magnetization, energy
    directed_rows = '{
      // rise of eight with zero threshold, at the lowest random value
      '{CMD_TRIAL,  0,  0, 32'h0000_0000, 0, 1, 0, 1,  4096, -8192},
      '{CMD_TRIAL, 63, 63, 32'hFFFF_FFFF, 1, 1, 0, 1,  4096, -8192},
      // unused command leaves everything as it stands
      '{CMD_NONE,  63,  0, 32'hAAAA_5555, 0, 1, 0, 1,  4096, -8192},
      // load without change still counts as accepted
      '{CMD_LOAD,   0,  0, 32'h0000_0000, 1, 1, 1, 1,  4096, -8192},
      '{CMD_LOAD,   0,  0, 32'h0000_0000, 0, 1, 1, 0,  4094, -8184},
      // drop of eight always accepted
      '{CMD_TRIAL,  0,  0, 32'hFFFF_FFFF, 1, 1, 1, 1,  4096, -8192},
      // zero energy change
      '{CMD_LOAD,  11, 10, 32'h1234_5678, 0, 0, 0, 0,     0,     0},
      '{CMD_LOAD,   9, 10, 32'h8765_4321, 0, 0, 0, 0,     0,     0},
      '{CMD_TRIAL, 10, 10, 32'h0000_0000, 1, 0, 0, 0,     0,     0},
      // rise of four with zero threshold
      '{CMD_LOAD,  21, 20, 32'h0F0F_0F0F, 0, 0, 0, 0,     0,     0},
      '{CMD_TRIAL, 20, 20, 32'h0000_0000, 0, 0, 0, 0,     0,     0},
      // neighbours wrapping across both lattice edges
      '{CMD_LOAD,  63, 63, 32'hF0F0_F0F0, 0, 0, 0, 0,     0,     0},
      '{CMD_LOAD,   0, 63, 32'h0000_0000, 0, 0, 0, 0,     0,     0},
      '{CMD_TRIAL, 63, 63, 32'h0000_0000, 1, 0, 0, 0,     0,     0},
      '{CMD_NONE,   0, 63, 32'hFFFF_FFFF, 1, 0, 0, 0,     0,     0},
      // fill all down, then a lone up spin in a down sea
      '{CMD_FILL,  37,  5, 32'h5A5A_A5A5, 0, 1, 1, 0, -4096, -8192},
      '{CMD_TRIAL,  5,  5, 32'h0000_0000, 0, 1, 0, 0, -4096, -8192},
      '{CMD_LOAD,   5,  5, 32'h0000_0000, 1, 1, 1, 1, -4094, -8184},
      '{CMD_TRIAL,  5,  5, 32'hFFFF_FFFF, 0, 1, 1, 0, -4096, -8192},
      '{CMD_FILL,   0,  0, 32'hFFFF_FFFF, 1, 1, 1, 1,  4096, -8192},
      '{CMD_TRIAL, 32, 31, 32'h0000_0001, 1, 1, 0, 1,  4096, -8192}
    };

    // thresholds per phase: extremes, mixed, and roughly critical temperature last
    phase_four  = '{32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h2C08_F6A7};
    phase_eight = '{32'hFFFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0795_2A3C};
    phase_four[1]  = $urandom;
    phase_eight[1] = $urandom;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed items under the reset thresholds
    foreach (directed_rows[i]) begin
      it.cmd  = directed_rows[i].cmd;
      it.x    = coord_t'(directed_rows[i].x);
      it.y    = coord_t'(directed_rows[i].y);
      it.rnd  = directed_rows[i].rnd;
      it.spin = directed_rows[i].spin;
      it.fixed = directed_rows[i].fixed;
      it.fixed_out.accepted   = directed_rows[i].acc;
      it.fixed_out.spin_after = directed_rows[i].spin_after;
      it.fixed_out.mag        = MAG_W'(directed_rows[i].mag);
      it.fixed_out.en         = EN_W'(directed_rows[i].en);
      send_item(it);
    end
    wait_for_results();

    // random phases, each starting from an idle block
    for (int p = 0; p < PHASE_COUNT; p++) begin
      set_thresholds(phase_four[p], phase_eight[p]);
      win_x = coord_t'($urandom);
      win_y = coord_t'($urandom);
      calm = (p == PHASE_COUNT - 1);
      repeat (ITEMS_PER_PHASE) send_item(random_item());
      wait_for_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule

>>> files.f
src/ising_pkg.sv
src/ising_ram.sv
src/ising_ctrl.sv
src/ising_dp.sv
src/ising_metropolis_spin_update_top.sv
tb/testbench.sv
